[rtl/core/dxtd_pkg.sv]
// Shared types, constants and arithmetic helpers for the DXT texture block decoder.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package dxtd_pkg;

  localparam int NumPix    = 16;
  localparam int PixCntW   = 4;
  localparam int InDataW   = 128;
  localparam int OutDataW  = 40;
  localparam int QDepth    = 2;
  localparam int QPtrW     = $clog2(QDepth);
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  // Reciprocal constants for truncating division of small sums.
  localparam logic [9:0]  Recip3 = 10'd683;   // exact below 2047
  localparam int          Shift3 = 11;
  localparam logic [11:0] Recip5 = 12'd3277;  // exact below 16000
  localparam logic [11:0] Recip7 = 12'd2341;  // exact below 5466
  localparam int          Shift57 = 14;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    rgb_t [3:0]       color_pal;
    logic [7:0][7:0]  alpha_pal;
    logic [31:0]      color_idx;
    logic [47:0]      alpha_idx;
    logic             dxt5;
  } blk_entry_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'(Recip3);
    return 8'(p >> Shift3);
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(Recip5);
    return 8'(p >> Shift57);
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(Recip7);
    return 8'(p >> Shift57);
  endfunction

endpackage

`default_nettype wire

[rtl/core/dxtd_front.sv]
// Front end: holds the format register and turns one compressed block into
// its colour and alpha palettes plus index words. Depends on dxtd_pkg.
`default_nettype none

module dxtd_front import dxtd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic [InDataW-1:0] blk_data,
  output blk_entry_t              entry
);

  logic format_mode_r;
  logic format_mode_nxt;

  always_comb begin
    format_mode_nxt = format_mode_r;
    if (cfg_wr_en) begin
      format_mode_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= 1'b0;
    end else begin
      format_mode_r <= format_mode_nxt;
    end
  end

  logic [63:0] alpha_bits;
  logic [63:0] color_bits;
  logic [15:0] q0;
  logic [15:0] q1;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic        four_color;
  logic [2:0][7:0] c0;  // channel order: blue, green, red
  logic [2:0][7:0] c1;
  logic [2:0][7:0] e2;
  logic [2:0][7:0] e3;
  logic [7:0][7:0] apal;

  assign alpha_bits = blk_data[63:0];
  assign color_bits = blk_data[127:64];
  assign q0 = color_bits[15:0];
  assign q1 = color_bits[31:16];
  assign a0 = alpha_bits[7:0];
  assign a1 = alpha_bits[15:8];
  assign four_color = q0 > q1;

  assign c0[2] = expand5(q0[15:11]);
  assign c0[1] = expand6(q0[10:5]);
  assign c0[0] = expand5(q0[4:0]);
  assign c1[2] = expand5(q1[15:11]);
  assign c1[1] = expand6(q1[10:5]);
  assign c1[0] = expand5(q1[4:0]);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (four_color) begin
        e2[ch] = div3({1'b0, c0[ch], 1'b0} + {2'b00, c1[ch]});
        e3[ch] = div3({2'b00, c0[ch]} + {1'b0, c1[ch], 1'b0});
      end else begin
        e2[ch] = 8'(({1'b0, c0[ch]} + {1'b0, c1[ch]}) >> 1);
        e3[ch] = 8'h00;
      end
    end
  end

  // Six sevenths steps when a0 > a1, otherwise four fifths steps plus 0 and 255.
  always_comb begin
    apal[0] = a0;
    apal[1] = a1;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        apal[k + 1] = div7(11'((7 - k) * a0 + k * a1));
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        apal[k + 1] = div5(11'((5 - k) * a0 + k * a1));
      end
      apal[6] = 8'h00;
      apal[7] = AlphaOpaque;
    end
  end

  always_comb begin
    entry.color_pal[0] = {c0[2], c0[1], c0[0]};
    entry.color_pal[1] = {c1[2], c1[1], c1[0]};
    entry.color_pal[2] = {e2[2], e2[1], e2[0]};
    entry.color_pal[3] = {e3[2], e3[1], e3[0]};
    entry.alpha_pal    = apal;
    entry.color_idx    = color_bits[63:32];
    entry.alpha_idx    = alpha_bits[63:16];
    entry.dxt5         = format_mode_r;
  end

endmodule

`default_nettype wire

[rtl/core/dxtd_queue.sv]
// Two-entry request queue between the palette front end and the pixel back end.
// Depends on dxtd_pkg for the entry type and depth.
`default_nettype none

module dxtd_queue import dxtd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire blk_entry_t push_data,
  output logic      full,
  input  wire logic pop,
  output blk_entry_t pop_data,
  output logic      nonempty
);

  blk_entry_t           slot_r [QDepth];
  logic [QPtrW-1:0]     wr_ptr_r;
  logic [QPtrW-1:0]     wr_ptr_nxt;
  logic [QPtrW-1:0]     rd_ptr_r;
  logic [QPtrW-1:0]     rd_ptr_nxt;
  logic [QCntW-1:0]     cnt_r;
  logic [QCntW-1:0]     cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full     = cnt_r == QCntW'(QDepth);
  assign nonempty = cnt_r != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/dxtd_back.sv]
// Back end: walks the sixteen pixels of one queued block and drives the
// registered result stream. Depends on dxtd_pkg.
`default_nettype none

module dxtd_back import dxtd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire blk_entry_t          q_entry,
  output logic                     q_pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,
  output logic                     out_tlast
);

  blk_entry_t         cur_r;
  blk_entry_t         cur_nxt;
  logic               act_r;
  logic               act_nxt;
  logic [PixCntW-1:0] cnt_r;
  logic [PixCntW-1:0] cnt_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic               out_last_r;

  logic               out_adv;
  logic               produce;
  logic               last_pix;
  rgb_t               pix_rgb;
  logic [7:0]         pix_alpha;

  assign out_adv  = !out_valid_r || out_tready;
  assign produce  = act_r && out_adv;
  assign last_pix = cnt_r == PixCntW'(NumPix - 1);
  // A new block is taken the same cycle its predecessor's last pixel is loaded.
  assign q_pop    = q_valid && (!act_r || (produce && last_pix));

  assign pix_rgb   = cur_r.color_pal[cur_r.color_idx[1:0]];
  assign pix_alpha = cur_r.dxt5 ? cur_r.alpha_pal[cur_r.alpha_idx[2:0]] : AlphaOpaque;

  always_comb begin
    cur_nxt       = cur_r;
    act_nxt       = act_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (produce) begin
      out_valid_nxt     = 1'b1;
      cnt_nxt           = cnt_r + 1'b1;
      cur_nxt.color_idx = cur_r.color_idx >> 2;
      cur_nxt.alpha_idx = cur_r.alpha_idx >> 3;
      if (last_pix) begin
        act_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_nxt = q_entry;
      cnt_nxt = '0;
      act_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (produce) begin
      out_data_r <= {4'h0, pix_alpha, pix_rgb[7:0], pix_rgb[15:8], pix_rgb[23:16], cnt_r};
      out_last_r <= last_pix;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/core/dxt_texture_block_decoder.sv]
// DXT1/DXT5 texture block decoder: one 4x4 block in, sixteen RGBA pixels out.
// A block passes from a queue slot to the back end's current-block register, and each pixel is registered on out_tdata.
// The output register takes one pixel per cycle while out_tready is high, sixteen pixels per block.
// A two-entry queue lets the next blocks be accepted while the current one drains.
// Reset (rst_n low, synchronous) empties the queue, idles the output and selects DXT1.
`default_nettype none

module dxt_texture_block_decoder import dxtd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [InDataW-1:0]  in_tdata,   // alpha_bits[63:0], color_bits[127:64]
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OutDataW-1:0]      out_tdata,  // pixel_index[3:0], red[11:4], green[19:12],
                                               // blue[27:20], alpha[35:28], zero[39:36]
  output logic                     out_tlast,  // last_pixel
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_wr_data // format_mode
);

  blk_entry_t front_entry;
  blk_entry_t q_entry;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;

  dxtd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .blk_data    (in_tdata),
    .entry       (front_entry)
  );

  dxtd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_entry),
    .nonempty  (q_valid)
  );

  assign in_tready = !q_full;

  dxtd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/core/dxtd_checker.sv]
// Port-level checks for the DXT texture block decoder, bound to the top level.
// Depends on dxtd_pkg for port widths.
`default_nettype none

module dxtd_checker import dxtd_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_tvalid,
  input wire logic                out_tready,
  input wire logic [OutDataW-1:0] out_tdata,
  input wire logic                out_tlast
);

  // A stalled pixel holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The last flag marks exactly pixel fifteen.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[3:0] == 4'hF)))
    else $error("last flag does not match pixel index");

  // Within a block, pixels follow each other without a gap.
  a_next_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[3:0] == 4'($past(out_tdata[3:0]) + 4'd1)))
    else $error("pixel sequence broken inside a block");

  // The pixel after the end of a block starts the next block.
  a_new_blk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> !out_tvalid || (out_tdata[3:0] == 4'h0))
    else $error("block did not restart at pixel zero");

endmodule

bind dxt_texture_block_decoder dxtd_checker u_dxtd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
